@@ rtl/tchm_pkg.sv @@
// ----------------------------------------------------------------------------
// tchm_pkg
// Shared types, sizes and helpers for the two-level cache hit/miss tracker.
// ----------------------------------------------------------------------------
package tchm_pkg;

    localparam int ADDR_W = 32;
    localparam int TAG_W  = 32;

    // L1 geometry; set counts are powers of two
    localparam int L1_SET_W = 6;
    localparam int L1_SETS  = 1 << L1_SET_W;
    localparam int L1_WAYS  = 4;
    localparam int L1_VIC_W = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
    localparam int L1_CNT_W = $clog2(L1_WAYS + 1);

    // L2 geometry
    localparam int L2_SET_W = 8;
    localparam int L2_SETS  = 1 << L2_SET_W;
    localparam int L2_WAYS  = 8;
    localparam int L2_VIC_W = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    localparam int L2_CNT_W = $clog2(L2_WAYS + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    typedef logic [L1_SET_W-1:0] l1_set_t;
    typedef logic [L1_VIC_W-1:0] l1_vic_t;
    typedef logic [L1_CNT_W-1:0] l1_cnt_t;
    typedef logic [L2_SET_W-1:0] l2_set_t;
    typedef logic [L2_VIC_W-1:0] l2_vic_t;
    typedef logic [L2_CNT_W-1:0] l2_cnt_t;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_RHIT  = 3'd1,
        ST_RMISS = 3'd2,
        ST_WHIT  = 3'd3,
        ST_WMISS = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L1_OFFSET = 3'd0,
        CFG_L1_SETS   = 3'd1,
        CFG_L1_WAYS   = 3'd2,
        CFG_L2_OFFSET = 3'd3,
        CFG_L2_SETS   = 3'd4,
        CFG_L2_WAYS   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [4:0] l1_offset_bits;
        logic [2:0] l1_set_bits;
        logic [2:0] l1_ways;
        logic [4:0] l2_offset_bits;
        logic [3:0] l2_set_bits;
        logic [3:0] l2_ways;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        l1_offset_bits: 5'd5,
        l1_set_bits:    3'd6,
        l1_ways:        3'd4,
        l2_offset_bits: 5'd6,
        l2_set_bits:    4'd8,
        l2_ways:        4'd8
    };

    // per-level control from the pipeline
    typedef struct packed {
        logic rd_en;   // item accepted: read its set row
        logic fill;    // refill the set of the item in the lookup stage
    } lvl_ctl_t;

    // one set row: pointer, per-way valid bits and tags
    typedef struct packed {
        l1_vic_t                       victim;
        logic [L1_WAYS-1:0]            valid;
        logic [L1_WAYS-1:0][TAG_W-1:0] tags;
    } l1_row_t;

    typedef struct packed {
        l2_vic_t                       victim;
        logic [L2_WAYS-1:0]            valid;
        logic [L2_WAYS-1:0][TAG_W-1:0] tags;
    } l2_row_t;

    // set index before wrapping to the array size
    function automatic logic [ADDR_W-1:0] set_index(
        input logic [ADDR_W-1:0] addr,
        input logic [4:0]        off,
        input logic [3:0]        sb
    );
        logic [ADDR_W-1:0] mask;
        mask = (ADDR_W'(1) << sb) - ADDR_W'(1);
        return (addr >> off) & mask;
    endfunction

    // tag is zero once the shift reaches the address width
    function automatic logic [TAG_W-1:0] tag_of(
        input logic [ADDR_W-1:0] addr,
        input logic [4:0]        off,
        input logic [3:0]        sb
    );
        logic [5:0] sh;
        sh = 6'(off) + 6'(sb);
        if (int'(sh) >= ADDR_W)
            return '0;
        return TAG_W'(addr >> sh);
    endfunction

endpackage

@@ rtl/tchm_ram.sv @@
// ----------------------------------------------------------------------------
// tchm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tchm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/tchm_l1.sv @@
// ----------------------------------------------------------------------------
// tchm_l1
// L1 tag store: set row RAM, row valid flops, lookup and round-robin refill.
// ----------------------------------------------------------------------------
module tchm_l1 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tchm_pkg::cfg_t                cfg,
    input  tchm_pkg::lvl_ctl_t            ctl,
    input  logic [tchm_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [tchm_pkg::ADDR_W-1:0]   addr,
    output logic                          hit
);

    logic [tchm_pkg::ADDR_W-1:0] rd_idx;
    logic [tchm_pkg::ADDR_W-1:0] cur_idx;
    tchm_pkg::l1_set_t           rd_set;
    tchm_pkg::l1_set_t           cur_set;
    logic [tchm_pkg::TAG_W-1:0]  tag;
    tchm_pkg::l1_row_t           dout;
    tchm_pkg::l1_row_t           row;
    tchm_pkg::l1_row_t           wr_row;
    tchm_pkg::l1_row_t           fwd_row_reg;
    logic                        fwd_reg;
    logic [tchm_pkg::L1_SETS-1:0] rv_reg;
    tchm_pkg::l1_cnt_t           n_ways;
    tchm_pkg::l1_vic_t           vic;

    assign rd_idx  = tchm_pkg::set_index(rd_addr, cfg.l1_offset_bits, 4'(cfg.l1_set_bits));
    assign cur_idx = tchm_pkg::set_index(addr, cfg.l1_offset_bits, 4'(cfg.l1_set_bits));
    assign rd_set  = rd_idx[tchm_pkg::L1_SET_W-1:0];
    assign cur_set = cur_idx[tchm_pkg::L1_SET_W-1:0];
    assign tag     = tchm_pkg::tag_of(addr, cfg.l1_offset_bits, 4'(cfg.l1_set_bits));

    tchm_ram #(
        .WIDTH ($bits(tchm_pkg::l1_row_t)),
        .DEPTH (tchm_pkg::L1_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.fill),
        .waddr (cur_set),
        .wdata (wr_row),
        .re    (ctl.rd_en),
        .raddr (rd_set),
        .rdata (dout)
    );

    // a refill landing on the set being read this edge is forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            fwd_reg <= ctl.fill && (cur_set == rd_set);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            fwd_row_reg <= wr_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= '0;
        end
        else if (ctl.fill)
        begin
            rv_reg[cur_set] <= 1'b1;
        end
    end

    always_comb
    begin
        priority if (fwd_reg)
            row = fwd_row_reg;
        else if (rv_reg[cur_set])
            row = dout;
        else
            row = '0;
    end

    always_comb
    begin
        priority if (cfg.l1_ways == '0)
            n_ways = tchm_pkg::l1_cnt_t'(1);
        else if (int'(cfg.l1_ways) > tchm_pkg::L1_WAYS)
            n_ways = tchm_pkg::l1_cnt_t'(tchm_pkg::L1_WAYS);
        else
            n_ways = tchm_pkg::l1_cnt_t'(cfg.l1_ways);
    end

    always_comb
    begin
        hit = 1'b0;
        for (int w = 0; w < tchm_pkg::L1_WAYS; w++)
        begin
            if ((w < int'(n_ways)) && row.valid[w] && (row.tags[w] == tag))
                hit = 1'b1;
        end
    end

    // stale pointer past the way count restarts at way 0
    always_comb
    begin
        vic    = (int'(row.victim) >= int'(n_ways)) ? '0 : row.victim;
        wr_row = row;
        wr_row.tags[vic]  = tag;
        wr_row.valid[vic] = 1'b1;
        wr_row.victim     = ((int'(vic) + 1) == int'(n_ways)) ? '0
                                                              : vic + tchm_pkg::l1_vic_t'(1);
    end

endmodule

@@ rtl/tchm_l2.sv @@
// ----------------------------------------------------------------------------
// tchm_l2
// L2 tag store: set row RAM, row valid flops, lookup and round-robin refill.
// ----------------------------------------------------------------------------
module tchm_l2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tchm_pkg::cfg_t                cfg,
    input  tchm_pkg::lvl_ctl_t            ctl,
    input  logic [tchm_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [tchm_pkg::ADDR_W-1:0]   addr,
    output logic                          hit
);

    logic [tchm_pkg::ADDR_W-1:0] rd_idx;
    logic [tchm_pkg::ADDR_W-1:0] cur_idx;
    tchm_pkg::l2_set_t           rd_set;
    tchm_pkg::l2_set_t           cur_set;
    logic [tchm_pkg::TAG_W-1:0]  tag;
    tchm_pkg::l2_row_t           dout;
    tchm_pkg::l2_row_t           row;
    tchm_pkg::l2_row_t           wr_row;
    tchm_pkg::l2_row_t           fwd_row_reg;
    logic                        fwd_reg;
    logic [tchm_pkg::L2_SETS-1:0] rv_reg;
    tchm_pkg::l2_cnt_t           n_ways;
    tchm_pkg::l2_vic_t           vic;

    assign rd_idx  = tchm_pkg::set_index(rd_addr, cfg.l2_offset_bits, cfg.l2_set_bits);
    assign cur_idx = tchm_pkg::set_index(addr, cfg.l2_offset_bits, cfg.l2_set_bits);
    assign rd_set  = rd_idx[tchm_pkg::L2_SET_W-1:0];
    assign cur_set = cur_idx[tchm_pkg::L2_SET_W-1:0];
    assign tag     = tchm_pkg::tag_of(addr, cfg.l2_offset_bits, cfg.l2_set_bits);

    tchm_ram #(
        .WIDTH ($bits(tchm_pkg::l2_row_t)),
        .DEPTH (tchm_pkg::L2_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.fill),
        .waddr (cur_set),
        .wdata (wr_row),
        .re    (ctl.rd_en),
        .raddr (rd_set),
        .rdata (dout)
    );

    // a refill landing on the set being read this edge is forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            fwd_reg <= ctl.fill && (cur_set == rd_set);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            fwd_row_reg <= wr_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= '0;
        end
        else if (ctl.fill)
        begin
            rv_reg[cur_set] <= 1'b1;
        end
    end

    always_comb
    begin
        priority if (fwd_reg)
            row = fwd_row_reg;
        else if (rv_reg[cur_set])
            row = dout;
        else
            row = '0;
    end

    always_comb
    begin
        priority if (cfg.l2_ways == '0)
            n_ways = tchm_pkg::l2_cnt_t'(1);
        else if (int'(cfg.l2_ways) > tchm_pkg::L2_WAYS)
            n_ways = tchm_pkg::l2_cnt_t'(tchm_pkg::L2_WAYS);
        else
            n_ways = tchm_pkg::l2_cnt_t'(cfg.l2_ways);
    end

    always_comb
    begin
        hit = 1'b0;
        for (int w = 0; w < tchm_pkg::L2_WAYS; w++)
        begin
            if ((w < int'(n_ways)) && row.valid[w] && (row.tags[w] == tag))
                hit = 1'b1;
        end
    end

    // stale pointer past the way count restarts at way 0
    always_comb
    begin
        vic    = (int'(row.victim) >= int'(n_ways)) ? '0 : row.victim;
        wr_row = row;
        wr_row.tags[vic]  = tag;
        wr_row.valid[vic] = 1'b1;
        wr_row.victim     = ((int'(vic) + 1) == int'(n_ways)) ? '0
                                                              : vic + tchm_pkg::l2_vic_t'(1);
    end

endmodule

@@ rtl/two_level_cache_hit_miss.sv @@
// ----------------------------------------------------------------------------
// two_level_cache_hit_miss
// Two-level set associative hit/miss tracker with round-robin refill.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                  payload
//  s_axis    in    s_axis_tvalid/tready       tdata: address, tuser: func
//  m_axis    out   m_axis_tvalid/tready       tdata: l1_status, l2_status
//  cfg       in    cfg_valid/cfg_ready        cfg_index, cfg_data
//
//  One item per cycle sustained while the output is not stalled; a result is
//  registered from the lookup stage. Each tag RAM's set row (registered read)
//  feeds the compare and refill logic, which writes it back on a read miss.
//  Reset clears the per-set valid flops, so no clearing pass is needed.
//  A stalled output holds the lookup stage; input is taken while it drains.
// ----------------------------------------------------------------------------
module two_level_cache_hit_miss (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // [31:0] address
    input  logic [0:0]                        s_axis_tuser,   // [0] func
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [2:0] l1_status,
                                                              // [5:3] l2_status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tchm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tchm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tchm_pkg::cfg_t              cfg_reg;
    tchm_pkg::cfg_t              cfg_next;
    logic                        s1_valid_reg;
    logic                        s1_func_reg;
    logic [tchm_pkg::ADDR_W-1:0] s1_addr_reg;
    logic                        out_valid_reg;
    tchm_pkg::status_t           l1_status_reg;
    tchm_pkg::status_t           l2_status_reg;
    tchm_pkg::status_t           l1_status_next;
    tchm_pkg::status_t           l2_status_next;
    logic                        accept;
    logic                        adv;
    logic                        l1_hit;
    logic                        l2_hit;
    tchm_pkg::lvl_ctl_t          l1_ctl;
    tchm_pkg::lvl_ctl_t          l2_ctl;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tchm_pkg::CFG_L1_OFFSET: cfg_next.l1_offset_bits = cfg_data[4:0];
                tchm_pkg::CFG_L1_SETS:   cfg_next.l1_set_bits    = cfg_data[2:0];
                tchm_pkg::CFG_L1_WAYS:   cfg_next.l1_ways        = cfg_data[2:0];
                tchm_pkg::CFG_L2_OFFSET: cfg_next.l2_offset_bits = cfg_data[4:0];
                tchm_pkg::CFG_L2_SETS:   cfg_next.l2_set_bits    = cfg_data[3:0];
                tchm_pkg::CFG_L2_WAYS:   cfg_next.l2_ways        = cfg_data[3:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tchm_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign adv           = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= s_axis_tuser[0];
            s1_addr_reg <= s_axis_tdata;
        end
    end

    // L2 is only consulted, and refilled, when L1 misses
    always_comb
    begin
        if (s1_func_reg)
        begin
            l1_status_next = l1_hit ? tchm_pkg::ST_WHIT : tchm_pkg::ST_WMISS;
            l2_status_next = l1_hit ? tchm_pkg::ST_NONE
                           : (l2_hit ? tchm_pkg::ST_WHIT : tchm_pkg::ST_WMISS);
        end
        else
        begin
            l1_status_next = l1_hit ? tchm_pkg::ST_RHIT : tchm_pkg::ST_RMISS;
            l2_status_next = l1_hit ? tchm_pkg::ST_NONE
                           : (l2_hit ? tchm_pkg::ST_RHIT : tchm_pkg::ST_RMISS);
        end
    end

    assign l1_ctl.rd_en = accept;
    assign l1_ctl.fill  = adv && !s1_func_reg && !l1_hit;
    assign l2_ctl.rd_en = accept;
    assign l2_ctl.fill  = adv && !s1_func_reg && !l1_hit && !l2_hit;

    tchm_l1 u_l1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .ctl     (l1_ctl),
        .rd_addr (s_axis_tdata),
        .addr    (s1_addr_reg),
        .hit     (l1_hit)
    );

    tchm_l2 u_l2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .ctl     (l2_ctl),
        .rd_addr (s_axis_tdata),
        .addr    (s1_addr_reg),
        .hit     (l2_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_status_reg <= l1_status_next;
            l2_status_reg <= l2_status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, l2_status_reg, l1_status_reg};

endmodule

@@ rtl/tchm_checker.sv @@
// ----------------------------------------------------------------------------
// tchm_checker
// Port-level checks for the two-level cache hit/miss tracker.
// ----------------------------------------------------------------------------
module tchm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [7:0]                      m_axis_tdata
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // L2 is reported only behind an L1 miss
    a_l2_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[5:3] != tchm_pkg::ST_NONE) |->
        (m_axis_tdata[2:0] == tchm_pkg::ST_RMISS) || (m_axis_tdata[2:0] == tchm_pkg::ST_WMISS))
        else $error("L2 status without L1 miss");

    // a write miss in L1 reports a write status in L2
    a_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == tchm_pkg::ST_WMISS) |->
        (m_axis_tdata[5:3] == tchm_pkg::ST_WHIT) || (m_axis_tdata[5:3] == tchm_pkg::ST_WMISS))
        else $error("L2 status kind differs from L1");

    // a new result follows an item accepted into the lookup stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without an accepted item");

    // empty output never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind two_level_cache_hit_miss tchm_checker u_tchm_checker (.*);
